/* rtl/fte_pkg.sv */
`default_nettype none
package fte_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_REC_END   = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_STRAY     = 2'd1;
  localparam logic [1:0] ERR_LINE_END  = 2'd2;
  localparam logic [1:0] ERR_INPUT_END = 2'd3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCLOSURE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTING   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAKS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [1:0]  error_code;
    logic [15:0] records_done;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } qent_t;

  typedef struct packed {
    logic  full;
    logic  empty;
  } qstat_t;

endpackage
`default_nettype wire

/* rtl/fte_front.sv */
`default_nettype none
module fte_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          acc_i,
  input  fte_pkg::in_req_t             in_req_i,
  input  wire                          cfg_we_i,
  input  wire [fte_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [fte_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                         q_wr_o,
  output fte_pkg::qent_t               q_data_o
);
  import fte_pkg::*;

  typedef struct packed {
    logic [7:0]  sep;
    logic [7:0]  enc;
    logic        quoting;
    logic        breaks;
    logic [15:0] limit;
  } cfg_t;

  typedef struct packed {
    logic        inq;
    logic        cqs;
    logic        crh;
    logic        afs;
    logic        ro;
    logic [15:0] cnt;
    logic [1:0]  n;
    res_t        r0;
    res_t        r1;
  } ps_t;

  function automatic ps_t f_emit(ps_t s, logic [1:0] kind, logic [7:0] b, logic [1:0] err);
    ps_t  o;
    res_t r;
    o = s;
    r.kind         = kind;
    r.data_byte    = (kind == KIND_DATA) ? b : 8'd0;
    r.error_code   = err;
    r.records_done = s.cnt;
    r.last_of_run  = 1'b0;
    if (s.n == 2'd0) begin
      o.r0 = r;
      o.n  = 2'd1;
    end else if (s.n == 2'd1) begin
      o.r1 = r;
      o.n  = 2'd2;
    end
    return o;
  endfunction

  function automatic ps_t f_clear(ps_t s);
    ps_t o;
    o = s;
    o.inq = 1'b0;
    o.cqs = 1'b0;
    o.crh = 1'b0;
    o.afs = 1'b1;
    o.ro  = 1'b0;
    return o;
  endfunction

  function automatic ps_t f_finish(ps_t s, logic [1:0] err);
    ps_t o;
    o = s;
    if (o.cnt != 16'hFFFF) begin
      o.cnt = o.cnt + 16'd1;
    end
    o = f_emit(o, KIND_REC_END, 8'd0, err);
    o = f_clear(o);
    return o;
  endfunction

  function automatic ps_t f_line_end(ps_t s, cfg_t c);
    ps_t o;
    o = s;
    if (s.inq && !s.cqs) begin
      if (c.breaks) begin
        o = f_emit(o, KIND_DATA, CH_LF, ERR_NONE);
        o.afs = 1'b0;
      end else begin
        o = f_finish(o, ERR_LINE_END);
      end
    end else begin
      o = f_finish(o, ERR_NONE);
    end
    return o;
  endfunction

  function automatic ps_t f_quoted(ps_t s, logic [7:0] b, cfg_t c);
    ps_t o;
    o = s;
    if (b == c.enc) begin
      o.cqs = 1'b1;
    end else if (b == CH_LF) begin
      o = f_line_end(o, c);
    end else if (b == CH_CR) begin
      o.crh = 1'b1;
    end else begin
      o = f_emit(o, KIND_DATA, b, ERR_NONE);
    end
    return o;
  endfunction

  function automatic ps_t f_take(ps_t s, logic [7:0] b, cfg_t c);
    ps_t o;
    o = s;
    if (s.cqs) begin
      if (b == c.enc) begin
        o = f_emit(o, KIND_DATA, b, ERR_NONE);
        o.cqs = 1'b0;
      end else if (b == c.sep) begin
        o.cqs = 1'b0;
        o.inq = 1'b0;
        o.afs = 1'b1;
        o = f_emit(o, KIND_FIELD_END, 8'd0, ERR_NONE);
      end else if (b == CH_LF) begin
        o = f_line_end(o, c);
      end else if (b == CH_CR) begin
        o.crh = 1'b1;
      end else begin
        o = f_emit(o, KIND_DATA, c.enc, ERR_STRAY);
        o.cqs = 1'b0;
        o = f_quoted(o, b, c);
      end
    end else if (s.inq) begin
      o = f_quoted(o, b, c);
    end else if (s.afs && c.quoting && b == c.enc) begin
      o.inq = 1'b1;
      o.afs = 1'b0;
    end else if (b == CH_LF) begin
      o = f_line_end(o, c);
    end else if (b == CH_CR) begin
      o.crh = 1'b1;
    end else if (b == c.sep) begin
      o.afs = 1'b1;
      o = f_emit(o, KIND_FIELD_END, 8'd0, ERR_NONE);
    end else begin
      o.afs = 1'b0;
      o = f_emit(o, KIND_DATA, b, ERR_NONE);
    end
    return o;
  endfunction

  cfg_t        cfg_q;
  logic        inq_q, cqs_q, crh_q, afs_q, ro_q;
  logic [15:0] cnt_q;
  ps_t         cur, nxt;
  logic        lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sep     <= 8'd44;
      cfg_q.enc     <= 8'd34;
      cfg_q.quoting <= 1'b1;
      cfg_q.breaks  <= 1'b0;
      cfg_q.limit   <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEPARATOR: cfg_q.sep     <= cfg_wdata_i[7:0];
        CFG_ENCLOSURE: cfg_q.enc     <= cfg_wdata_i[7:0];
        CFG_QUOTING:   cfg_q.quoting <= cfg_wdata_i[0];
        CFG_BREAKS:    cfg_q.breaks  <= cfg_wdata_i[0];
        CFG_LIMIT:     cfg_q.limit   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur     = '0;
    cur.inq = inq_q;
    cur.cqs = cqs_q;
    cur.crh = crh_q;
    cur.afs = afs_q;
    cur.ro  = ro_q;
    cur.cnt = cnt_q;
    lim     = (cfg_q.limit != 16'd0) && (cnt_q >= cfg_q.limit);
    nxt     = cur;
    if (in_req_i.end_of_input) begin
      if (!lim) begin
        if (nxt.crh) begin
          nxt.crh = 1'b0;
          nxt = f_line_end(nxt, cfg_q);
        end
        if (nxt.ro) begin
          nxt = f_finish(nxt, (nxt.inq && !nxt.cqs) ? ERR_INPUT_END : ERR_NONE);
        end
      end
      nxt = f_clear(nxt);
    end else if (!lim) begin
      nxt.ro = 1'b1;
      if (nxt.crh) begin
        nxt.crh = 1'b0;
        if (in_req_i.in_byte == CH_LF) begin
          nxt = f_line_end(nxt, cfg_q);
        end else begin
          if (nxt.cqs) begin
            nxt = f_emit(nxt, KIND_DATA, cfg_q.enc, ERR_STRAY);
            nxt.cqs = 1'b0;
          end else begin
            nxt = f_emit(nxt, KIND_DATA, CH_CR, ERR_NONE);
            nxt.afs = 1'b0;
          end
          nxt = f_take(nxt, in_req_i.in_byte, cfg_q);
        end
      end else begin
        nxt = f_take(nxt, in_req_i.in_byte, cfg_q);
      end
    end
    if (nxt.n == 2'd2) begin
      nxt.r1.last_of_run = 1'b1;
    end else begin
      nxt.r0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_q <= 1'b0;
      cqs_q <= 1'b0;
      crh_q <= 1'b0;
      afs_q <= 1'b1;
      ro_q  <= 1'b0;
      cnt_q <= 16'd0;
    end else if (acc_i) begin
      inq_q <= nxt.inq;
      cqs_q <= nxt.cqs;
      crh_q <= nxt.crh;
      afs_q <= nxt.afs;
      ro_q  <= nxt.ro;
      cnt_q <= nxt.cnt;
    end
  end

  assign q_wr_o        = acc_i && (nxt.n != 2'd0);
  assign q_data_o.two  = (nxt.n == 2'd2);
  assign q_data_o.r0   = nxt.r0;
  assign q_data_o.r1   = nxt.r1;

endmodule
`default_nettype wire

/* rtl/fte_queue.sv */
`default_nettype none
module fte_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            wr_i,
  input  fte_pkg::qent_t wdata_i,
  input  wire            rd_i,
  output fte_pkg::qent_t rdata_o,
  output fte_pkg::qstat_t stat_o
);
  import fte_pkg::*;

  qent_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_wr, do_rd;

  assign stat_o.full  = (cnt_q == QDEPTH[QPTR_W:0]);
  assign stat_o.empty = (cnt_q == '0);
  assign do_wr        = wr_i && !stat_o.full;
  assign do_rd        = rd_i && !stat_o.empty;
  assign rdata_o      = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= rp_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/fte_back.sv */
`default_nettype none
module fte_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  fte_pkg::qent_t  q_data_i,
  input  fte_pkg::qstat_t q_stat_i,
  output logic            q_rd_o,
  input  wire             pop_i,
  output logic            empty_o,
  output fte_pkg::res_t   res_o
);
  import fte_pkg::*;

  res_t out_q, hold_q;
  logic out_v_q, hold_v_q;
  logic adv;

  assign adv     = !out_v_q || pop_i;
  assign q_rd_o  = adv && !hold_v_q && !q_stat_i.empty;
  assign empty_o = !out_v_q;
  assign res_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (hold_v_q) begin
        out_q <= hold_q;
      end else begin
        out_q  <= q_data_i.r0;
        hold_q <= q_data_i.r1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
    end else if (adv) begin
      if (hold_v_q) begin
        out_v_q  <= 1'b1;
        hold_v_q <= 1'b0;
      end else begin
        out_v_q  <= !q_stat_i.empty;
        hold_v_q <= !q_stat_i.empty && q_data_i.two;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/csv_field_tokenizer.sv */
// CSV field tokenizer.
// Input channel: present a text byte or an end-of-input mark on in_req_i
// with push_i; the request is taken on a clock edge where push_i is high
// and full_o is low. Each request yields zero, one or two result requests.
// Result channel: while empty_o is low, res_o holds the oldest result
// (field byte, end of field, or end of record, each with error code, record
// count and last-of-run flag); pop_i takes it.
// A request's results are written to the queue on the edge that takes it
// and reach res_o through the output register. Throughput is one input byte
// per cycle while full_o is low and each byte gives at most one result; a
// byte giving two results keeps its second in a hold register until pop.
// A four-entry queue between the parser and the output stage absorbs
// stalls: when pop_i stays low, the queue fills and full_o rises.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i;
// write only while the block is idle.
// Reset clears parse state, the record count, the queue and the output,
// and restores default separator, enclosure, quoting, breaks and limit settings.
`default_nettype none
module csv_field_tokenizer (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           push_i,
  output logic                          full_o,
  input  fte_pkg::in_req_t              in_req_i,
  output logic                          empty_o,
  input  wire                           pop_i,
  output fte_pkg::res_t                 res_o,
  input  wire                           cfg_we_i,
  input  wire [fte_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [fte_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import fte_pkg::*;

  qent_t  wr_data, rd_data;
  qstat_t q_stat;
  logic   q_wr, q_rd, acc;

  assign full_o = q_stat.full;
  assign acc    = push_i && !q_stat.full;

  fte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .in_req_i   (in_req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_wr_o     (q_wr),
    .q_data_o   (wr_data)
  );

  fte_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .wdata_i(wr_data),
    .rd_i   (q_rd),
    .rdata_o(rd_data),
    .stat_o (q_stat)
  );

  fte_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_data_i(rd_data),
    .q_stat_i(q_stat),
    .q_rd_o  (q_rd),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .res_o   (res_o)
  );

endmodule
`default_nettype wire

/* rtl/fte_checker.sv */
`default_nettype none
module fte_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           empty_o,
  input wire           pop_i,
  input fte_pkg::res_t res_o
);
  import fte_pkg::*;

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && !res_o.last_of_run) |=> !empty_o)
    else $error("second result of a request not ready");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && res_o.kind != KIND_DATA) |-> (res_o.data_byte == 8'd0))
    else $error("nonzero byte on a field or record end");

  a_quote_err_on_rec_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (res_o.error_code == ERR_LINE_END || res_o.error_code == ERR_INPUT_END))
    |-> (res_o.kind == KIND_REC_END))
    else $error("quote error without record end");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i) |=> (empty_o || res_o.records_done >= $past(res_o.records_done)))
    else $error("record count went backward");

endmodule

bind csv_field_tokenizer fte_checker u_fte_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty_o(empty_o),
  .pop_i  (pop_i),
  .res_o  (res_o)
);
`default_nettype wire

/* tb/csv_field_tokenizer_tb.sv */
`default_nettype none
module csv_field_tokenizer_tb;
  import fte_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [7:0] SEP_DEF = 8'h2C;
  localparam logic [7:0] ENC_DEF = 8'h22;
  localparam res_t NO_RES = '0;

  typedef struct packed {
    in_req_t req;
    logic    typed;
    res_t    want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic full_o;
  in_req_t in_req_i = '0;
  logic empty_o;
  logic pop_i = 1'b0;
  res_t res_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  csv_field_tokenizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_req_i    (in_req_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // scanner model: configuration and parse state
  logic [7:0]  sep_c = SEP_DEF;
  logic [7:0]  enc_c = ENC_DEF;
  logic        quote_en = 1'b1;
  logic        brk_en = 1'b0;
  logic [15:0] lim_c = 16'd0;
  bit          in_q, cq_seen, cr_hold, rec_open;
  bit          fld_start = 1'b1;
  logic [15:0] rec_cnt = 16'd0;

  res_t step_toks[$];
  res_t expected_tokens[$];
  bit   step_taken;
  int   taken_count = 0;
  int   mismatches = 0;
  int   tok_idx = 0;
  int   cycle_cnt = 0;
  int   gap_pct = 25;
  int   pop_idle_pct = 25;
  row_t dir_rows[$];

  task automatic put_tok(input logic [1:0] kind, input logic [7:0] b,
                         input logic [1:0] err);
    res_t t;
    if (step_toks.size() < 2) begin
      t.kind = kind;
      t.data_byte = (kind == KIND_DATA) ? b : 8'h00;
      t.error_code = err;
      t.records_done = rec_cnt;
      t.last_of_run = 1'b0;
      step_toks.push_back(t);
    end
  endtask

  function automatic bit limit_hit();
    return lim_c != 16'd0 && rec_cnt >= lim_c;
  endfunction

  task automatic clear_parse();
    in_q = 1'b0;
    cq_seen = 1'b0;
    cr_hold = 1'b0;
    fld_start = 1'b1;
    rec_open = 1'b0;
  endtask

  task automatic close_record(input logic [1:0] err);
    if (rec_cnt != 16'hFFFF) rec_cnt++;
    put_tok(KIND_REC_END, 8'h00, err);
    clear_parse();
  endtask

  task automatic line_break();
    if (in_q && !cq_seen) begin
      if (brk_en) begin
        put_tok(KIND_DATA, CH_LF, ERR_NONE);
        fld_start = 1'b0;
      end else begin
        close_record(ERR_LINE_END);
      end
    end else begin
      close_record(ERR_NONE);
    end
  endtask

  task automatic quoted_byte(input logic [7:0] b);
    if (b == enc_c) cq_seen = 1'b1;
    else if (b == CH_LF) line_break();
    else if (b == CH_CR) cr_hold = 1'b1;
    else put_tok(KIND_DATA, b, ERR_NONE);
  endtask

  task automatic scan_byte(input logic [7:0] b);
    if (cq_seen) begin
      if (b == enc_c) begin
        put_tok(KIND_DATA, b, ERR_NONE);
        cq_seen = 1'b0;
      end else if (b == sep_c) begin
        cq_seen = 1'b0;
        in_q = 1'b0;
        fld_start = 1'b1;
        put_tok(KIND_FIELD_END, 8'h00, ERR_NONE);
      end else if (b == CH_LF) begin
        line_break();
      end else if (b == CH_CR) begin
        cr_hold = 1'b1;
      end else begin
        put_tok(KIND_DATA, enc_c, ERR_STRAY);
        cq_seen = 1'b0;
        quoted_byte(b);
      end
    end else if (in_q) begin
      quoted_byte(b);
    end else if (fld_start && quote_en && b == enc_c) begin
      in_q = 1'b1;
      fld_start = 1'b0;
    end else if (b == CH_LF) begin
      line_break();
    end else if (b == CH_CR) begin
      cr_hold = 1'b1;
    end else if (b == sep_c) begin
      fld_start = 1'b1;
      put_tok(KIND_FIELD_END, 8'h00, ERR_NONE);
    end else begin
      fld_start = 1'b0;
      put_tok(KIND_DATA, b, ERR_NONE);
    end
  endtask

  task automatic tokenize(input in_req_t r);
    logic [7:0] b;
    bit skip;
    res_t t;
    b = r.in_byte;
    skip = 1'b0;
    step_toks.delete();
    step_taken = 1'b0;
    if (r.end_of_input) begin
      if (!limit_hit()) begin
        step_taken = 1'b1;
        if (cr_hold) begin
          cr_hold = 1'b0;
          line_break();
        end
        if (rec_open) close_record((in_q && !cq_seen) ? ERR_INPUT_END : ERR_NONE);
      end
      clear_parse();
    end else if (!limit_hit()) begin
      step_taken = 1'b1;
      rec_open = 1'b1;
      if (cr_hold) begin
        cr_hold = 1'b0;
        if (b == CH_LF) begin
          line_break();
          skip = 1'b1;
        end else if (cq_seen) begin
          put_tok(KIND_DATA, enc_c, ERR_STRAY);
          cq_seen = 1'b0;
        end else begin
          put_tok(KIND_DATA, CH_CR, ERR_NONE);
          fld_start = 1'b0;
        end
      end
      if (!skip) scan_byte(b);
    end
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last_of_run = 1'b1;
      step_toks.push_back(t);
    end
  endtask

  // request side
  task automatic send(input in_req_t r, input bit typed, input res_t want);
    int n;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 8);
      @(negedge clk_i) push_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (full_o);
    tokenize(r);
    if (step_taken) taken_count++;
    if (typed) begin
      step_toks.delete();
      step_toks.push_back(want);
    end
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send({b, 1'b0}, 1'b0, NO_RES);
  endtask

  task automatic send_eoi();
    send({8'($urandom_range(0, 255)), 1'b1}, 1'b0, NO_RES);
  endtask

  task automatic send_noise();
    in_req_t r;
    r.end_of_input = ($urandom_range(0, 29) == 0);
    case ($urandom_range(0, 9))
      0, 1: r.in_byte = enc_c;
      2:    r.in_byte = sep_c;
      3:    r.in_byte = CH_LF;
      4:    r.in_byte = CH_CR;
      5:    r.in_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: r.in_byte = 8'($urandom_range(0, 255));
    endcase
    send(r, 1'b0, NO_RES);
  endtask

  function automatic logic [7:0] pick_content(input bit quoted);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == enc_c || b == CH_LF || b == CH_CR || (!quoted && b == sep_c));
    return b;
  endfunction

  task automatic send_record();
    int nf, len;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) send_byte(sep_c);
      len = $urandom_range(0, 4);
      if (quote_en && $urandom_range(0, 1)) begin
        send_byte(enc_c);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 7))
            0: begin
              send_byte(enc_c);
              send_byte(enc_c);
            end
            1: begin
              if (brk_en) begin
                if ($urandom_range(0, 1)) send_byte(CH_CR);
                send_byte(CH_LF);
              end else begin
                send_byte(pick_content(1'b1));
              end
            end
            default: send_byte(pick_content(1'b1));
          endcase
        end
        send_byte(enc_c);
      end else begin
        for (int i = 0; i < len; i++) send_byte(pick_content(1'b0));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      send_eoi();
    end else begin
      if ($urandom_range(0, 1)) send_byte(CH_CR);
      send_byte(CH_LF);
    end
  endtask

  task automatic run_phase(input int n_items);
    int start;
    start = taken_count;
    while (taken_count - start < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        send_record();
      end else begin
        repeat ($urandom_range(1, 6)) send_noise();
      end
    end
  endtask

  task automatic settle();
    @(negedge clk_i) push_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_SEPARATOR: sep_c = val[7:0];
      CFG_ENCLOSURE: enc_c = val[7:0];
      CFG_QUOTING:   quote_en = val[0];
      CFG_BREAKS:    brk_en = val[0];
      CFG_LIMIT:     lim_c = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [7:0] sep, input logic [7:0] enc, input logic quo,
                           input logic brk, input logic [15:0] lim);
    cfg_write(CFG_SEPARATOR, {8'h00, sep});
    cfg_write(CFG_ENCLOSURE, {8'h00, enc});
    cfg_write(CFG_QUOTING, {15'd0, quo});
    cfg_write(CFG_BREAKS, {15'd0, brk});
    cfg_write(CFG_LIMIT, lim);
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  // result side
  initial begin
    forever begin
      @(negedge clk_i);
      if (pop_idle_pct != 0 && $urandom_range(0, 99) < pop_idle_pct) begin
        pop_i <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_b
    res_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token %0d: unexpected request kind %0d byte %h err %0d count %0d",
                   tok_idx, res_o.kind, res_o.data_byte, res_o.error_code,
                   res_o.records_done);
      end else begin
        want = expected_tokens.pop_front();
        if (res_o.kind !== want.kind || res_o.data_byte !== want.data_byte ||
            res_o.error_code !== want.error_code ||
            res_o.records_done !== want.records_done ||
            res_o.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("token %0d: exp kind %0d byte %h err %0d count %0d last %0d,",
                     tok_idx, want.kind, want.data_byte, want.error_code,
                     want.records_done, want.last_of_run);
            $display("  got kind %0d byte %h err %0d count %0d last %0d",
                     res_o.kind, res_o.data_byte, res_o.error_code,
                     res_o.records_done, res_o.last_of_run);
          end
        end
      end
      tok_idx++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    dir_rows.push_back({CH_LF,   1'b0, 1'b1, {KIND_REC_END, 8'h00, ERR_NONE, 16'd1, 1'b1}});
    dir_rows.push_back({8'h00,   1'b0, 1'b1, {KIND_DATA, 8'h00, ERR_NONE, 16'd1, 1'b1}});
    dir_rows.push_back({8'hFF,   1'b0, 1'b1, {KIND_DATA, 8'hFF, ERR_NONE, 16'd1, 1'b1}});
    dir_rows.push_back({SEP_DEF, 1'b0, 1'b1, {KIND_FIELD_END, 8'h00, ERR_NONE, 16'd1, 1'b1}});
    dir_rows.push_back({ENC_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({ENC_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({ENC_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({ENC_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({SEP_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({ENC_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({"x",     1'b0, 1'b0, NO_RES});
    dir_rows.push_back({ENC_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({"y",     1'b0, 1'b0, NO_RES});
    dir_rows.push_back({CH_LF,   1'b0, 1'b1, {KIND_REC_END, 8'h00, ERR_LINE_END, 16'd2, 1'b1}});
    dir_rows.push_back({ENC_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({ENC_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({CH_CR,   1'b0, 1'b0, NO_RES});
    dir_rows.push_back({CH_LF,   1'b0, 1'b1, {KIND_REC_END, 8'h00, ERR_NONE, 16'd3, 1'b1}});
    dir_rows.push_back({CH_CR,   1'b0, 1'b0, NO_RES});
    dir_rows.push_back({"b",     1'b0, 1'b0, NO_RES});
    dir_rows.push_back({SEP_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({ENC_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({ENC_DEF, 1'b0, 1'b0, NO_RES});
    dir_rows.push_back({CH_CR,   1'b0, 1'b0, NO_RES});
    dir_rows.push_back({"z",     1'b0, 1'b0, NO_RES});
    dir_rows.push_back({8'hA5,   1'b1, 1'b1, {KIND_REC_END, 8'h00, ERR_INPUT_END, 16'd4, 1'b1}});
    dir_rows.push_back({8'h5A,   1'b1, 1'b0, NO_RES});

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    run_phase(120);

    settle();
    apply_cfg(8'h00, 8'hFF, 1'b1, 1'b1, 16'd0);
    pop_idle_pct = 50;
    run_phase(120);

    settle();
    apply_cfg(8'hFF, 8'h00, 1'b0, 1'b0, 16'd0);
    gap_pct = 50;
    pop_idle_pct = 10;
    run_phase(100);

    settle();
    apply_cfg(CH_CR, CH_LF, 1'b1, 1'b1, 16'd0);
    gap_pct = 15;
    pop_idle_pct = 30;
    run_phase(60);

    settle();
    apply_cfg("|", "|", 1'b1, 1'b0, 16'd0);
    run_phase(60);

    settle();
    apply_cfg(";", 8'h27, 1'b1, 1'b1, rec_cnt + 16'd3);
    while (!limit_hit()) send_record();
    repeat (10) send_noise();
    send_eoi();
    repeat (3) send_noise();

    settle();
    apply_cfg(SEP_DEF, ENC_DEF, 1'b1, 1'b0, 16'd1);
    repeat (6) send_noise();
    send_eoi();

    settle();
    apply_cfg(SEP_DEF, ENC_DEF, 1'b1, 1'b0, 16'd0);
    gap_pct = 0;
    pop_idle_pct = 0;
    run_phase(30);

    settle();
    apply_cfg(SEP_DEF, ENC_DEF, 1'b1, 1'b0, 16'hFFFF);
    repeat (5) send_noise();
    send_eoi();

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/fte_pkg.sv
rtl/fte_front.sv
rtl/fte_queue.sv
rtl/fte_back.sv
rtl/csv_field_tokenizer.sv
rtl/fte_checker.sv
tb/csv_field_tokenizer_tb.sv
